// ----- hw/rtl/qrs_pkg.sv -----
// Shared types and constants for the quadratic root solver.
`default_nettype none
package qrs_pkg;
  localparam int COEF_WIDTH_DEF     = 16;
  localparam int COEF_FRAC_BITS_DEF = 8;
  localparam int ROOT_WIDTH         = 32;
  localparam int ROOT_FRAC_BITS     = 16;

  typedef enum logic [1:0] {
    KIND_REAL_PAIR = 2'd0,
    KIND_COMPLEX   = 2'd1,
    KIND_DOUBLE    = 2'd2
  } root_kind_t;
endpackage
`default_nettype wire

// ----- hw/rtl/qrs_coef_if.sv -----
// Input channel carrying one set of coefficients per beat.
`default_nettype none
interface qrs_coef_if #(parameter int COEF_WIDTH = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COEF_WIDTH-1:0] coef_a;
  logic signed [COEF_WIDTH-1:0] coef_b;
  logic signed [COEF_WIDTH-1:0] coef_c;

  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/qrs_root_if.sv -----
// Output channel carrying one root result per beat.
`default_nettype none
interface qrs_root_if
  import qrs_pkg::*;
  ();
  logic                         valid;
  logic                         ready;
  logic [1:0]                   root_kind;
  logic signed [ROOT_WIDTH-1:0] first_root;
  logic signed [ROOT_WIDTH-1:0] second_root;
  logic signed [ROOT_WIDTH-1:0] imag_part;
  logic                         zero_leading;
  logic                         saturated;

  modport source (output valid, root_kind, first_root, second_root, imag_part,
                  zero_leading, saturated, input ready);
  modport sink (input valid, root_kind, first_root, second_root, imag_part,
                zero_leading, saturated, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/qrs_sqrt_cell.sv -----
// One cell of the square root chain: settles one root bit per cell.
`default_nettype none
module qrs_sqrt_cell #(
  parameter int RW = 25,
  parameter int XW = 50,
  parameter int PW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_vld,
  input  wire logic [XW-1:0] in_x,
  input  wire logic [RW+1:0] in_r,
  input  wire logic [RW-1:0] in_q,
  input  wire logic [PW-1:0] in_p,
  output logic               out_vld,
  output logic [XW-1:0]      out_x,
  output logic [RW+1:0]      out_r,
  output logic [RW-1:0]      out_q,
  output logic [PW-1:0]      out_p
);
  logic [RW+3:0] trial;
  logic [RW+3:0] sub;
  logic          take;

  always_comb begin
    trial = {in_r, in_x[XW-1:XW-2]};
    sub   = (RW+4)'({in_q, 2'b01});
    take  = trial >= sub;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x <= in_x << 2;
      out_r <= take ? (RW+2)'(trial - sub) : (RW+2)'(trial);
      out_q <= {in_q[RW-2:0], take};
      out_p <= in_p;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/qrs_div_cell.sv -----
// One cell of a restoring divider chain: settles one quotient bit per cell.
`default_nettype none
module qrs_div_cell #(
  parameter int NW = 35,
  parameter int VW = 17,
  parameter int PW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_vld,
  input  wire logic [NW-1:0] in_n,
  input  wire logic [VW-1:0] in_rem,
  input  wire logic [NW-1:0] in_q,
  input  wire logic [VW-1:0] in_dv,
  input  wire logic [PW-1:0] in_p,
  output logic               out_vld,
  output logic [NW-1:0]      out_n,
  output logic [VW-1:0]      out_rem,
  output logic [NW-1:0]      out_q,
  output logic [VW-1:0]      out_dv,
  output logic [PW-1:0]      out_p
);
  logic [VW:0] trial;
  logic        take;

  always_comb begin
    trial = {in_rem, in_n[NW-1]};
    take  = trial >= {1'b0, in_dv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_n   <= in_n << 1;
      out_rem <= take ? VW'(trial - {1'b0, in_dv}) : VW'(trial);
      out_q   <= {in_q[NW-2:0], take};
      out_dv  <= in_dv;
      out_p   <= in_p;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/quadratic_root_solver.sv -----
// Top level of the fixed-point quadratic root solver.
// Takes signed fixed-point a, b and c (by default 16-bit Q8.8) and returns the roots in Q16.16.
// One coefficient set is accepted every cycle while the output is not stalled. Each result passes
// through the product, discriminant, square root (one cell per root bit), numerator, divider (one
// cell per quotient bit) and output stages. The whole pipeline holds only while a finished result
// waits at the output and the sink is not ready.
`default_nettype none
module quadratic_root_solver
  import qrs_pkg::*;
#(
  parameter int COEF_WIDTH     = COEF_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  qrs_coef_if.sink  coef,
  qrs_root_if.source roots
);
  localparam int CW   = COEF_WIDTH;
  localparam int F    = COEF_FRAC_BITS;
  localparam int G    = ROOT_FRAC_BITS - F;
  localparam int DW   = 2 * CW + 2;
  localparam int MW   = 2 * CW + 1;
  localparam int XW0  = MW + 2 * G;
  localparam int XW   = XW0 + (XW0 % 2);
  localparam int RW   = XW / 2;
  localparam int NBW  = CW + G + 1;
  localparam int NNW  = ((NBW > RW + 1) ? NBW : RW + 1) + 1;
  localparam int NW   = NNW + F;
  localparam int VW   = CW + 1;
  localparam int QX   = (NW > ROOT_WIDTH + 1) ? NW : ROOT_WIDTH + 1;
  localparam int SPW  = 2 * CW + 3;

  logic en;
  assign en         = !roots.valid || roots.ready;
  assign coef.ready = en;

  // Stage 0: products.
  logic                   s0_vld;
  logic signed [CW-1:0]   s0_a, s0_b;
  logic signed [2*CW-1:0] s0_bb, s0_ac;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (en) begin
      s0_vld <= coef.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_a  <= coef.coef_a;
      s0_b  <= coef.coef_b;
      s0_bb <= coef.coef_b * coef.coef_b;
      s0_ac <= coef.coef_a * coef.coef_c;
    end
  end

  // Stage 1: discriminant, its magnitude and the root kind.
  logic signed [DW-1:0] d_c;
  logic [DW-1:0]        dabs_c;
  root_kind_t           kind_c;

  always_comb begin
    d_c    = DW'(s0_bb) - (DW'(s0_ac) <<< 2);
    dabs_c = d_c[DW-1] ? DW'(-d_c) : DW'(d_c);
    if (d_c[DW-1]) begin
      kind_c = KIND_COMPLEX;
    end else if (d_c == '0) begin
      kind_c = KIND_DOUBLE;
    end else begin
      kind_c = KIND_REAL_PAIR;
    end
  end

  logic          s1_vld;
  logic [MW-1:0] s1_dmag;
  logic [SPW-1:0] s1_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= s0_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dmag <= MW'(dabs_c);
      s1_p    <= {s0_a, s0_b, 1'b0, kind_c};
    end
  end

  // Square root chain.
  logic           sq_vld [0:RW];
  logic [XW-1:0]  sq_x   [0:RW];
  logic [RW+1:0]  sq_r   [0:RW];
  logic [RW-1:0]  sq_q   [0:RW];
  logic [SPW-1:0] sq_p   [0:RW];

  assign sq_vld[0] = s1_vld;
  assign sq_x[0]   = XW'(s1_dmag) << (2 * G);
  assign sq_r[0]   = '0;
  assign sq_q[0]   = '0;
  assign sq_p[0]   = s1_p;

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    qrs_sqrt_cell #(.RW(RW), .XW(XW), .PW(SPW)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_vld(sq_vld[i]), .in_x(sq_x[i]), .in_r(sq_r[i]), .in_q(sq_q[i]), .in_p(sq_p[i]),
      .out_vld(sq_vld[i+1]), .out_x(sq_x[i+1]), .out_r(sq_r[i+1]), .out_q(sq_q[i+1]),
      .out_p(sq_p[i+1])
    );
  end

  // Stage 3: numerators, signs and divisor.
  logic signed [CW-1:0]  t_a, t_b;
  root_kind_t            t_kind;
  logic signed [NNW-1:0] t_nb, t_s;
  logic signed [NNW-1:0] t_n [0:2];
  logic [NNW-1:0]        t_nabs [0:2];
  logic [VW-1:0]         t_amag;

  always_comb begin
    t_a    = sq_p[RW][SPW-1 -: CW];
    t_b    = sq_p[RW][SPW-1-CW -: CW];
    t_kind = root_kind_t'(sq_p[RW][1:0]);
    t_nb   = -(NNW'(t_b) <<< G);
    t_s    = NNW'({1'b0, sq_q[RW]});
    t_n[0] = (t_kind == KIND_REAL_PAIR) ? t_nb + t_s : t_nb;
    t_n[1] = (t_kind == KIND_REAL_PAIR) ? t_nb - t_s : t_nb;
    t_n[2] = (t_kind == KIND_COMPLEX) ? t_s : '0;
    for (int k = 0; k < 3; k++) begin
      t_nabs[k] = t_n[k][NNW-1] ? NNW'(-t_n[k]) : NNW'(t_n[k]);
    end
    t_amag = t_a[CW-1] ? VW'(-VW'(t_a)) : VW'(t_a);
  end

  logic          s3_vld;
  logic [NW-1:0] s3_num [0:2];
  logic [2:0]    s3_neg;
  logic [VW-1:0] s3_dv;
  root_kind_t    s3_kind;
  logic          s3_zl;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (en) begin
      s3_vld <= sq_vld[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s3_num[k] <= NW'(t_nabs[k]) << F;
        s3_neg[k] <= t_n[k][NNW-1] ^ t_a[CW-1];
      end
      s3_dv   <= t_amag << 1;
      s3_kind <= t_kind;
      s3_zl   <= (t_a == '0);
    end
  end

  // Three divider chains: first root, second root, imaginary part.
  logic [NW-1:0] qt [0:2];
  logic          qneg [0:2];
  logic          d_vld;
  root_kind_t    d_kind;
  logic          d_zl;

  for (genvar k = 0; k < 3; k++) begin : g_div
    localparam int PW = (k == 0) ? 4 : 1;
    logic          dc_vld [0:NW];
    logic [NW-1:0] dc_n   [0:NW];
    logic [VW-1:0] dc_rem [0:NW];
    logic [NW-1:0] dc_q   [0:NW];
    logic [VW-1:0] dc_dv  [0:NW];
    logic [PW-1:0] dc_p   [0:NW];

    assign dc_vld[0] = s3_vld;
    assign dc_n[0]   = s3_num[k];
    assign dc_rem[0] = '0;
    assign dc_q[0]   = '0;
    assign dc_dv[0]  = s3_dv;
    if (k == 0) begin : g_side
      assign dc_p[0] = {s3_kind, s3_zl, s3_neg[k]};
      assign d_kind  = root_kind_t'(dc_p[NW][3:2]);
      assign d_zl    = dc_p[NW][1];
      assign d_vld   = dc_vld[NW];
    end else begin : g_plain
      assign dc_p[0] = s3_neg[k];
    end
    assign qt[k]   = dc_q[NW];
    assign qneg[k] = dc_p[NW][0];

    for (genvar i = 0; i < NW; i++) begin : g_cell
      qrs_div_cell #(.NW(NW), .VW(VW), .PW(PW)) u_cell (
        .clk(clk), .rst(rst), .en(en),
        .in_vld(dc_vld[i]), .in_n(dc_n[i]), .in_rem(dc_rem[i]), .in_q(dc_q[i]),
        .in_dv(dc_dv[i]), .in_p(dc_p[i]),
        .out_vld(dc_vld[i+1]), .out_n(dc_n[i+1]), .out_rem(dc_rem[i+1]), .out_q(dc_q[i+1]),
        .out_dv(dc_dv[i+1]), .out_p(dc_p[i+1])
      );
    end
  end

  // Final stage: sign, saturation and the output register.
  logic [QX-1:0]         qx [0:2];
  logic [ROOT_WIDTH-1:0] fin [0:2];
  logic [2:0]            fsat;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qx[k]   = QX'(qt[k]);
      fsat[k] = 1'b0;
      if (!qneg[k]) begin
        if (qx[k] > QX'({1'b0, {(ROOT_WIDTH-1){1'b1}}})) begin
          fsat[k] = 1'b1;
          fin[k]  = {1'b0, {(ROOT_WIDTH-1){1'b1}}};
        end else begin
          fin[k]  = ROOT_WIDTH'(qx[k]);
        end
      end else begin
        if (qx[k] > QX'({1'b1, {(ROOT_WIDTH-1){1'b0}}})) begin
          fsat[k] = 1'b1;
          fin[k]  = {1'b1, {(ROOT_WIDTH-1){1'b0}}};
        end else begin
          fin[k]  = ROOT_WIDTH'(-qx[k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      roots.valid <= 1'b0;
    end else if (en) begin
      roots.valid <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roots.root_kind    <= d_kind;
      roots.first_root   <= d_zl ? '0 : fin[0];
      roots.second_root  <= d_zl ? '0 : fin[1];
      roots.imag_part    <= d_zl ? '0 : fin[2];
      roots.zero_leading <= d_zl;
      roots.saturated    <= !d_zl && (|fsat);
    end
  end

`ifndef SYNTHESIS
  a_zero_lead_clear: assert property (@(posedge clk) disable iff (rst)
    roots.valid && roots.zero_leading |->
      roots.first_root == '0 && roots.second_root == '0 && roots.imag_part == '0 &&
      !roots.saturated)
    else $error("zero leading coefficient gave nonzero roots");

  a_real_no_imag: assert property (@(posedge clk) disable iff (rst)
    roots.valid && roots.root_kind != KIND_COMPLEX |-> roots.imag_part == '0)
    else $error("imaginary part set on a real result");

  a_double_equal: assert property (@(posedge clk) disable iff (rst)
    roots.valid && roots.root_kind != KIND_REAL_PAIR |-> roots.first_root == roots.second_root)
    else $error("double or complex result with differing real parts");
`endif
endmodule
`default_nettype wire
